FILE: rtl/ppqs_pkg.sv
// Package for the priority push-out queue with servers.
// Holds shared types, event and register codes, and fixed field widths.
// No dependencies.
`default_nettype none

package ppqs_pkg;

   localparam int MASK_W     = 8;
   localparam int COUNT_W    = 6;
   localparam int TICKS_W    = 16;
   localparam int IDX_W      = 3;
   localparam int KIND_W     = 3;
   localparam int SERVER_W   = 2;
   localparam int MAX_SERVERS = 4;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [COUNT_W-1:0] QUEUE_LIMIT_RESET = COUNT_W'(6);
   localparam logic [MAX_SERVERS-1:0][TICKS_W-1:0] SERVICE_TICKS_RESET = {
      TICKS_W'(70), TICKS_W'(70), TICKS_W'(100), TICKS_W'(70)
   };

   typedef enum logic [KIND_W-1:0] {
      EV_ADMIT    = 3'd0,
      EV_PUSHOUT  = 3'd1,
      EV_REFUSE   = 3'd2,
      EV_START    = 3'd3,
      EV_TICK_END = 3'd4
   } event_kind_type;

   typedef enum logic [2:0] {
      REG_QUEUE_LIMIT = 3'd0,
      REG_SERVICE_0   = 3'd1,
      REG_SERVICE_1   = 3'd2,
      REG_SERVICE_2   = 3'd3,
      REG_SERVICE_3   = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ARRIVE,
      ST_DISPATCH,
      ST_TICK_END
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_ARRIVE,
      OP_DISPATCH,
      OP_TICK_END
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [IDX_W-1:0] idx;
   } cmd_type;

endpackage

`default_nettype wire

FILE: rtl/ppqs_csr.sv
// Configuration registers: queue limit and per-server service ticks.
// APB-style write/read port; uses ppqs_pkg.
`default_nettype none

module ppqs_csr (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   psel,
   input  wire logic                                   penable,
   input  wire logic                                   pwrite,
   input  wire logic [ppqs_pkg::CSR_ADDR_W-1:0]        paddr,
   input  wire logic [ppqs_pkg::CSR_DATA_W-1:0]        pwdata,
   output logic      [ppqs_pkg::CSR_DATA_W-1:0]        prdata,
   output logic                                        pready,
   output logic      [ppqs_pkg::COUNT_W-1:0]           queue_limit,
   output logic      [ppqs_pkg::MAX_SERVERS-1:0][ppqs_pkg::TICKS_W-1:0] service_ticks
);
   import ppqs_pkg::*;

   logic [COUNT_W-1:0]                    queue_limit_ff, queue_limit_in;
   logic [MAX_SERVERS-1:0][TICKS_W-1:0]   service_ticks_ff, service_ticks_in;
   logic                                  wr_en;
   reg_index_type                         reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = reg_index_type'(paddr[CSR_ADDR_W-1:2]);

   always_comb begin
      queue_limit_in   = queue_limit_ff;
      service_ticks_in = service_ticks_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_QUEUE_LIMIT: queue_limit_in      = pwdata[COUNT_W-1:0];
            REG_SERVICE_0:   service_ticks_in[0] = pwdata[TICKS_W-1:0];
            REG_SERVICE_1:   service_ticks_in[1] = pwdata[TICKS_W-1:0];
            REG_SERVICE_2:   service_ticks_in[2] = pwdata[TICKS_W-1:0];
            REG_SERVICE_3:   service_ticks_in[3] = pwdata[TICKS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_QUEUE_LIMIT: prdata = CSR_DATA_W'(queue_limit_ff);
         REG_SERVICE_0:   prdata = CSR_DATA_W'(service_ticks_ff[0]);
         REG_SERVICE_1:   prdata = CSR_DATA_W'(service_ticks_ff[1]);
         REG_SERVICE_2:   prdata = CSR_DATA_W'(service_ticks_ff[2]);
         REG_SERVICE_3:   prdata = CSR_DATA_W'(service_ticks_ff[3]);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         queue_limit_ff   <= QUEUE_LIMIT_RESET;
         service_ticks_ff <= SERVICE_TICKS_RESET;
      end else begin
         queue_limit_ff   <= queue_limit_in;
         service_ticks_ff <= service_ticks_in;
      end
   end

   assign queue_limit   = queue_limit_ff;
   assign service_ticks = service_ticks_ff;

endmodule

`default_nettype wire

FILE: rtl/ppqs_ctrl.sv
// Tick sequencer: walks arrivals per priority, then servers, then tick end.
// Issues commands to ppqs_datapath; uses ppqs_pkg.
`default_nettype none

module ppqs_ctrl #(
   parameter int PRIORITIES = 3,
   parameter int SERVERS    = 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              rsp_ready,
   input  wire logic              out_full,
   output ppqs_pkg::cmd_type      cmd
);
   import ppqs_pkg::*;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               step_ok;

   assign step_ok = !out_full || rsp_ready;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_ARRIVE;
               idx_in   = '0;
            end
         end
         ST_ARRIVE: begin
            if (step_ok) begin
               if (idx_ff == IDX_W'(PRIORITIES - 1)) begin
                  state_in = ST_DISPATCH;
                  idx_in   = '0;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         ST_DISPATCH: begin
            if (step_ok) begin
               if (idx_ff == IDX_W'(SERVERS - 1)) begin
                  state_in = ST_TICK_END;
                  idx_in   = '0;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         ST_TICK_END: begin
            if (step_ok) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd.op    = OP_NONE;
      cmd.idx   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = OP_LOAD;
         end
         ST_ARRIVE:   if (step_ok) cmd.op = OP_ARRIVE;
         ST_DISPATCH: if (step_ok) cmd.op = OP_DISPATCH;
         ST_TICK_END: if (step_ok) cmd.op = OP_TICK_END;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/ppqs_datapath.sv
// Queue counts, server timers and the result register.
// Executes commands from ppqs_ctrl; uses ppqs_pkg.
`default_nettype none

module ppqs_datapath #(
   parameter int PRIORITIES = 3,
   parameter int SERVERS    = 2
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire ppqs_pkg::cmd_type                      cmd,
   input  wire logic [ppqs_pkg::MASK_W-1:0]            req_arrival_mask,
   input  wire logic [ppqs_pkg::COUNT_W-1:0]           queue_limit,
   input  wire logic [ppqs_pkg::MAX_SERVERS-1:0][ppqs_pkg::TICKS_W-1:0] service_ticks,
   input  wire logic                                   rsp_ready,
   output logic                                        out_full,
   output logic                                        rsp_valid,
   output logic      [ppqs_pkg::KIND_W-1:0]            rsp_event_kind,
   output logic      [ppqs_pkg::IDX_W-1:0]             rsp_priority_res,
   output logic      [ppqs_pkg::IDX_W-1:0]             rsp_victim_priority,
   output logic      [ppqs_pkg::SERVER_W-1:0]          rsp_server_index,
   output logic      [ppqs_pkg::COUNT_W-1:0]           rsp_occupancy,
   output logic                                        rsp_last
);
   import ppqs_pkg::*;

   logic [PRIORITIES-1:0]                 mask_ff, mask_in;
   logic [PRIORITIES-1:0][COUNT_W-1:0]    counts_ff, counts_in;
   logic [COUNT_W-1:0]                    total_ff, total_in;
   logic [SERVERS-1:0][TICKS_W-1:0]       remaining_ff, remaining_in;

   logic                                  valid_ff, valid_in;
   event_kind_type                        kind_ff, kind_in;
   logic [IDX_W-1:0]                      prio_ff, prio_in;
   logic [IDX_W-1:0]                      victim_ff, victim_in;
   logic [SERVER_W-1:0]                   server_ff, server_in;
   logic [COUNT_W-1:0]                    occ_ff;
   logic                                  last_ff, last_in;

   logic                                  emit;
   logic                                  arriving;
   logic                                  victim_found;
   logic [IDX_W-1:0]                      victim_idx;
   logic                                  head_found;
   logic [IDX_W-1:0]                      head_idx;
   logic                                  server_free;
   logic [TICKS_W-1:0]                    ticks_sel;

   always_comb begin
      arriving     = 1'b0;
      victim_found = 1'b0;
      victim_idx   = '0;
      head_found   = 1'b0;
      head_idx     = '0;
      server_free  = 1'b0;
      ticks_sel    = '0;
      for (int j = 0; j < PRIORITIES; j++) begin
         if (IDX_W'(j) == cmd.idx) arriving = mask_ff[j];
         if (IDX_W'(j) > cmd.idx && counts_ff[j] != '0) begin
            victim_found = 1'b1;
            victim_idx   = IDX_W'(j);
         end
      end
      for (int j = PRIORITIES - 1; j >= 0; j--) begin
         if (counts_ff[j] != '0) begin
            head_found = 1'b1;
            head_idx   = IDX_W'(j);
         end
      end
      for (int s = 0; s < SERVERS; s++) begin
         if (IDX_W'(s) == cmd.idx) server_free = (remaining_ff[s] == '0);
      end
      for (int s = 0; s < MAX_SERVERS; s++) begin
         if (IDX_W'(s) == cmd.idx) ticks_sel = service_ticks[s];
      end
   end

   always_comb begin
      mask_in      = mask_ff;
      counts_in    = counts_ff;
      total_in     = total_ff;
      remaining_in = remaining_ff;
      emit         = 1'b0;
      kind_in      = EV_TICK_END;
      prio_in      = '0;
      victim_in    = '0;
      server_in    = '0;
      last_in      = 1'b0;
      case (cmd.op)
         OP_LOAD: begin
            mask_in = req_arrival_mask[PRIORITIES-1:0];
            for (int s = 0; s < SERVERS; s++) begin
               if (remaining_ff[s] != '0) remaining_in[s] = remaining_ff[s] - TICKS_W'(1);
            end
         end
         OP_ARRIVE: begin
            if (arriving) begin
               emit    = 1'b1;
               prio_in = cmd.idx;
               if (total_ff < queue_limit) begin
                  kind_in  = EV_ADMIT;
                  total_in = total_ff + COUNT_W'(1);
                  for (int j = 0; j < PRIORITIES; j++) begin
                     if (IDX_W'(j) == cmd.idx) counts_in[j] = counts_ff[j] + COUNT_W'(1);
                  end
               end else if (victim_found) begin
                  kind_in   = EV_PUSHOUT;
                  victim_in = victim_idx;
                  for (int j = 0; j < PRIORITIES; j++) begin
                     if (IDX_W'(j) == cmd.idx) counts_in[j] = counts_ff[j] + COUNT_W'(1);
                     if (IDX_W'(j) == victim_idx) counts_in[j] = counts_ff[j] - COUNT_W'(1);
                  end
               end else begin
                  kind_in = EV_REFUSE;
               end
            end
         end
         OP_DISPATCH: begin
            if (server_free && head_found) begin
               emit      = 1'b1;
               kind_in   = EV_START;
               prio_in   = head_idx;
               server_in = cmd.idx[SERVER_W-1:0];
               total_in  = total_ff - COUNT_W'(1);
               for (int j = 0; j < PRIORITIES; j++) begin
                  if (IDX_W'(j) == head_idx) counts_in[j] = counts_ff[j] - COUNT_W'(1);
               end
               for (int s = 0; s < SERVERS; s++) begin
                  if (IDX_W'(s) == cmd.idx) remaining_in[s] = ticks_sel;
               end
            end
         end
         OP_TICK_END: begin
            emit    = 1'b1;
            kind_in = EV_TICK_END;
            last_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      if (emit) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counts_ff    <= '0;
         total_ff     <= '0;
         remaining_ff <= '0;
         valid_ff     <= 1'b0;
      end else begin
         counts_ff    <= counts_in;
         total_ff     <= total_in;
         remaining_ff <= remaining_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff <= mask_in;
      if (emit) begin
         kind_ff   <= kind_in;
         prio_ff   <= prio_in;
         victim_ff <= victim_in;
         server_ff <= server_in;
         occ_ff    <= total_in;
         last_ff   <= last_in;
      end
   end

   assign out_full            = valid_ff;
   assign rsp_valid           = valid_ff;
   assign rsp_event_kind      = kind_ff;
   assign rsp_priority_res    = prio_ff;
   assign rsp_victim_priority = victim_ff;
   assign rsp_server_index    = server_ff;
   assign rsp_occupancy       = occ_ff;
   assign rsp_last            = last_ff;

endmodule

`default_nettype wire

FILE: rtl/priority_pushout_queue_servers.sv
// Priority queue with push-out feeding a pool of servers, one tick per request transfer.
// Top level: instantiates ppqs_csr, ppqs_ctrl and ppqs_datapath; uses ppqs_pkg.
//
// Each request transfer carries one tick's arrival mask (bit k: one arrival of priority k).
// The tick produces, in order, one response per arrival (admitted, pushed out, refused),
// one per server that starts service, and a closing tick-end response with last set.
// The sequencer takes the request transfer (servers count down there), then steps
// through each priority class and each server, then the tick end. Responses leave
// through a single output register, so the first response becomes valid after the
// request state and the first arrival step. When the receiver stalls, the sequencer
// holds at the current step until the output register is free; a new request is taken
// as soon as the tick-end response is loaded, even while that response still waits.
// Reset empties all classes, frees all servers, drops any pending response and restores
// the register defaults (limit 6; service 70, 100, 70, 70 ticks). Registers are to be
// written by the user through the APB-style port only while idle; the block itself
// does not enforce this.
`default_nettype none

module priority_pushout_queue_servers #(
   parameter int PRIORITIES = 3,
   parameter int SERVERS    = 2
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [ppqs_pkg::MASK_W-1:0]        req_arrival_mask,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic      [ppqs_pkg::KIND_W-1:0]        rsp_event_kind,
   output logic      [ppqs_pkg::IDX_W-1:0]         rsp_priority_res,
   output logic      [ppqs_pkg::IDX_W-1:0]         rsp_victim_priority,
   output logic      [ppqs_pkg::SERVER_W-1:0]      rsp_server_index,
   output logic      [ppqs_pkg::COUNT_W-1:0]       rsp_occupancy,
   output logic                                    rsp_last,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [ppqs_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [ppqs_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic      [ppqs_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                    pready
);
   import ppqs_pkg::*;

   logic [COUNT_W-1:0]                    queue_limit;
   logic [MAX_SERVERS-1:0][TICKS_W-1:0]   service_ticks;
   cmd_type                               cmd;
   logic                                  out_full;

   ppqs_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .queue_limit   (queue_limit),
      .service_ticks (service_ticks)
   );

   ppqs_ctrl #(
      .PRIORITIES (PRIORITIES),
      .SERVERS    (SERVERS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .out_full  (out_full),
      .cmd       (cmd)
   );

   ppqs_datapath #(
      .PRIORITIES (PRIORITIES),
      .SERVERS    (SERVERS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .req_arrival_mask    (req_arrival_mask),
      .queue_limit         (queue_limit),
      .service_ticks       (service_ticks),
      .rsp_ready           (rsp_ready),
      .out_full            (out_full),
      .rsp_valid           (rsp_valid),
      .rsp_event_kind      (rsp_event_kind),
      .rsp_priority_res    (rsp_priority_res),
      .rsp_victim_priority (rsp_victim_priority),
      .rsp_server_index    (rsp_server_index),
      .rsp_occupancy       (rsp_occupancy),
      .rsp_last            (rsp_last)
   );

endmodule

`default_nettype wire
